@@ rtl/core/framebuffer_draw_engine_assert.svh @@
// Assertion macros shared by the draw engine modules.
`ifndef FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define FDE_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("draw engine check failed");
// The expression must never be true outside reset.
`define FDE_ASSERT_NEVER(lbl, ck, rn, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
        else $error("draw engine forbidden condition seen");
`else
`define FDE_ASSERT(lbl, ck, rn, prop)
`define FDE_ASSERT_NEVER(lbl, ck, rn, expr)
`endif
`endif

@@ rtl/core/fde_pkg.sv @@
// Shared types, constants and helpers of the frame buffer draw engine.
package fde_pkg;

    localparam int FB_WIDTH_DEF  = 320;
    localparam int FB_HEIGHT_DEF = 240;

    // Clipped pixel coordinates, rectangle bounds and signed corner coordinates.
    localparam int COORD_W = 12;
    localparam int BND_W   = 14;
    localparam int CRN_W   = 15;

    localparam logic [15:0] GLYPH_MSB = 16'h8000;

    localparam logic [2:0] MODE_PIXEL = 3'd0;
    localparam logic [2:0] MODE_FILL  = 3'd1;
    localparam logic [2:0] MODE_ROUND = 3'd2;
    localparam logic [2:0] MODE_GLYPH = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;
    localparam logic [2:0] MODE_READ  = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [11:0] width;
        logic [11:0] height;
        logic [7:0]  radius;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic [15:0] glyph_bits;
        logic [3:0]  scale;
    } fde_in_t;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [2:0]  done_mode;
    } fde_out_t;

    typedef enum logic [1:0] {
        SRC_CMD,
        SRC_PIXEL,
        SRC_CLEAR,
        SRC_GLYPH
    } rect_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        logic      rect_load;
        rect_src_t rect_src;
        logic      rect_run;
        logic      glyph_adv;
        logic      corner_run;
        logic      rd_issue;
        logic      res_load;
    } fde_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] mode;
        logic       rect_empty;
        logic       rect_last;
        logic       glyph_none;
        logic       glyph_last;
        logic       corner_none;
        logic       corner_last;
        logic       rd_done;
    } fde_stat_t;

    function automatic logic [15:0] swap16(input logic [15:0] c);
        return {c[7:0], c[15:8]};
    endfunction

endpackage

@@ rtl/core/framebuffer_draw_engine.sv @@
// Pixel, fill and clear write their clipped pixels one after another, a read goes through
// the same pipeline, and a glyph row paints one scale-by-scale block per column.
// A round rectangle then walks its radius*radius corner points and repaints each one outside
// the arc as four mirrored pixels.
// Throughput: one pixel per cycle through the single write port, one item at a time.
// Reset clears the sequencer, pipeline tokens and result valid, but not the frame memory.
module framebuffer_draw_engine #(
    parameter int FB_WIDTH  = fde_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = fde_pkg::FB_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  fde_pkg::fde_in_t   cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output fde_pkg::fde_out_t  rsp
);

    // The controller takes one item at a time.  Once it is captured, the
    // sequencer breaks the command into clipped rectangles (a pixel, a fill,
    // the whole buffer, or one glyph block per column) and, for rounded
    // rectangles, a walk over the corner quadrant that repaints the points
    // outside the arc in the background colour, four mirrored pixels each.
    //
    // Every pixel, and every read, goes through the same three-stage path:
    // coordinate register, address multiply by the buffer width, and the
    // frame memory itself.  Sharing the path keeps reads ordered behind all
    // earlier writes without any extra hazard logic.
    //
    // The result sits in an output register, so the next item may be
    // accepted while a finished result still waits for the consumer.

    fde_pkg::fde_ctl_t  ctl;
    fde_pkg::fde_stat_t stat;

    fde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    fde_dp #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

@@ rtl/core/fde_ctrl.sv @@
// Command sequencer of the draw engine and the result valid flag.
`include "framebuffer_draw_engine_assert.svh"
module fde_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  fde_pkg::fde_stat_t   stat,
    output fde_pkg::fde_ctl_t    ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RECT,
        S_GLYPH,
        S_CORNER,
        S_READ,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        ctl            = '0;
        ctl.rect_src   = fde_pkg::SRC_CMD;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.mode)
                    fde_pkg::MODE_PIXEL:
                    begin
                        ctl.rect_load = 1'b1;
                        ctl.rect_src  = fde_pkg::SRC_PIXEL;
                        state_next    = S_RECT;
                    end
                    fde_pkg::MODE_FILL, fde_pkg::MODE_ROUND:
                    begin
                        ctl.rect_load = 1'b1;
                        state_next    = S_RECT;
                    end
                    fde_pkg::MODE_CLEAR:
                    begin
                        ctl.rect_load = 1'b1;
                        ctl.rect_src  = fde_pkg::SRC_CLEAR;
                        state_next    = S_RECT;
                    end
                    fde_pkg::MODE_GLYPH:
                    begin
                        if (stat.glyph_none)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ctl.rect_load = 1'b1;
                            ctl.rect_src  = fde_pkg::SRC_GLYPH;
                            state_next    = S_RECT;
                        end
                    end
                    fde_pkg::MODE_READ:
                    begin
                        ctl.rd_issue = 1'b1;
                        state_next   = S_READ;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_RECT:
            begin
                ctl.rect_run = !stat.rect_empty;
                if (stat.rect_empty || stat.rect_last)
                begin
                    if (stat.mode == fde_pkg::MODE_ROUND)
                    begin
                        state_next = stat.corner_none ? S_FINISH : S_CORNER;
                    end
                    else if (stat.mode == fde_pkg::MODE_GLYPH && !stat.glyph_last)
                    begin
                        ctl.glyph_adv = 1'b1;
                        state_next    = S_GLYPH;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_GLYPH:
            begin
                ctl.rect_load = 1'b1;
                ctl.rect_src  = fde_pkg::SRC_GLYPH;
                state_next    = S_RECT;
            end
            S_CORNER:
            begin
                ctl.corner_run = 1'b1;
                if (stat.corner_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                if (stat.rd_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    ctl.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    // A new result is only written into a free or departing output slot.
    `FDE_ASSERT(a_res_slot_free, clk, rst_n, ctl.res_load |-> (!out_valid_reg || !rsp_stall))
    // Read data only comes back while the sequencer waits for it.
    `FDE_ASSERT(a_rd_when_waiting, clk, rst_n, stat.rd_done |-> (state_reg == S_READ))
    // An accepted item always goes on to decoding.
    `FDE_ASSERT(a_accept_decode, clk, rst_n, (cmd_valid && !cmd_stall) |=> (state_reg == S_DISPATCH))

endmodule

@@ rtl/core/fde_dp.sv @@
// Datapath of the draw engine: walkers, write pipeline and frame memory.
`include "framebuffer_draw_engine_assert.svh"
module fde_dp #(
    parameter int FB_WIDTH  = fde_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = fde_pkg::FB_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fde_pkg::fde_in_t     cmd,
    input  fde_pkg::fde_ctl_t    ctl,
    output fde_pkg::fde_stat_t   stat,
    output fde_pkg::fde_out_t    rsp
);

    localparam int PIXELS  = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W  = $clog2(PIXELS);
    localparam int BND_W   = fde_pkg::BND_W;
    localparam int CRN_W   = fde_pkg::CRN_W;
    localparam int COORD_W = fde_pkg::COORD_W;
    localparam logic [ADDR_W:0]    ADDR_LIM = (ADDR_W + 1)'(PIXELS);
    localparam logic [BND_W-1:0]   BND_FBW  = BND_W'(FB_WIDTH);
    localparam logic [BND_W-1:0]   BND_FBH  = BND_W'(FB_HEIGHT);
    localparam logic [CRN_W-1:0]   CRN_FBW  = CRN_W'(FB_WIDTH);
    localparam logic [CRN_W-1:0]   CRN_FBH  = CRN_W'(FB_HEIGHT);
    localparam logic [COORD_W-1:0] CRD_FBW  = COORD_W'(FB_WIDTH);
    localparam logic [COORD_W-1:0] CRD_FBH  = COORD_W'(FB_HEIGHT);

    // Captured command.
    logic [2:0]  mode_reg;
    logic [11:0] x_reg, y_reg, w_reg, h_reg;
    logic [7:0]  rad_reg;
    logic [15:0] fg_reg, bg_reg;
    logic [3:0]  sc_reg;

    // Glyph walker.
    logic [15:0] bits_reg;
    logic [3:0]  gcol_reg;
    logic [7:0]  goff_reg;
    logic [4:0]  wlim_reg;

    // Rectangle walker.
    logic [BND_W-1:0] xs_reg, x1_reg, y1_reg, cx_reg, cy_reg;
    logic [15:0]      rcol_reg;
    logic             empty_reg;
    logic [BND_W-1:0] lx, ly, lw, lh, lx_end, ly_end, lx1, ly1;
    logic [15:0]      lcol;
    logic             lempty, wrap;

    // Corner walker.
    logic [7:0]       row_reg, col_reg, dx_reg, dy_reg;
    logic [1:0]       q_reg;
    logic [15:0]      rsq_reg, dxsq_reg, dysq_reg, sq_next;
    logic [CRN_W-1:0] left_reg, right_reg, top_reg, bot_reg;
    logic [CRN_W-1:0] left_base, right_base, cand_x, cand_y;
    logic             hit, cand_ok, col_end, row_end;

    // Write and read pipeline.
    logic               p_we_reg, p_tok_reg, p_ok_reg;
    logic [COORD_W-1:0] p_x_reg, p_y_reg;
    logic [15:0]        p_data_reg;
    logic               p_we_next, p_ok_next;
    logic [COORD_W-1:0] p_x_next, p_y_next;
    logic [15:0]        p_data_next;
    logic               a_we_reg, a_tok_reg, a_ok_reg;
    logic [ADDR_W-1:0]  a_addr_reg;
    logic [ADDR_W:0]    a_addr_ext;
    logic [15:0]        a_data_reg;
    logic               r_tok_reg, r_ok_reg;
    logic [15:0]        rdata_reg, rd_pix_reg;
    logic [15:0]        frame_store [PIXELS];

    fde_pkg::fde_out_t  rsp_reg;

    // Command capture and glyph column stepping.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            mode_reg <= cmd.mode;
            x_reg    <= cmd.pos_x;
            y_reg    <= cmd.pos_y;
            w_reg    <= cmd.width;
            h_reg    <= cmd.height;
            rad_reg  <= cmd.radius;
            fg_reg   <= fde_pkg::swap16(cmd.fg_color);
            bg_reg   <= fde_pkg::swap16(cmd.bg_color);
            sc_reg   <= cmd.scale;
            bits_reg <= cmd.glyph_bits;
            gcol_reg <= '0;
            goff_reg <= '0;
            wlim_reg <= (cmd.width > 12'd16) ? 5'd16 : cmd.width[4:0];
        end
        else if (ctl.glyph_adv)
        begin
            bits_reg <= {bits_reg[14:0], 1'b0};
            gcol_reg <= gcol_reg + 4'd1;
            goff_reg <= goff_reg + 8'(sc_reg);
        end
    end

    // Rectangle set-up: the source picks the corner and size, then it is clipped.
    always_comb
    begin
        lx   = BND_W'(x_reg);
        ly   = BND_W'(y_reg);
        lw   = BND_W'(w_reg);
        lh   = BND_W'(h_reg);
        lcol = fg_reg;
        case (ctl.rect_src)
            fde_pkg::SRC_CMD:
            begin
                lx = BND_W'(x_reg);
            end
            fde_pkg::SRC_PIXEL:
            begin
                lw = BND_W'(1);
                lh = BND_W'(1);
            end
            fde_pkg::SRC_CLEAR:
            begin
                lx = '0;
                ly = '0;
                lw = BND_FBW;
                lh = BND_FBH;
            end
            fde_pkg::SRC_GLYPH:
            begin
                lx   = BND_W'(x_reg) + BND_W'(goff_reg);
                lw   = BND_W'(sc_reg);
                lh   = BND_W'(sc_reg);
                lcol = ((bits_reg & fde_pkg::GLYPH_MSB) != 16'd0) ? fg_reg : bg_reg;
            end
            default:
            begin
                lx = BND_W'(x_reg);
            end
        endcase
        lx_end = lx + lw;
        ly_end = ly + lh;
        lx1    = (lx_end > BND_FBW) ? BND_FBW : lx_end;
        ly1    = (ly_end > BND_FBH) ? BND_FBH : ly_end;
        lempty = (lx >= lx1) || (ly >= ly1);
    end

    assign wrap = (cx_reg + BND_W'(1)) == x1_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rect_load)
        begin
            xs_reg    <= lx;
            x1_reg    <= lx1;
            y1_reg    <= ly1;
            cx_reg    <= lx;
            cy_reg    <= ly;
            rcol_reg  <= lcol;
            empty_reg <= lempty;
        end
        else if (ctl.rect_run)
        begin
            if (wrap)
            begin
                cx_reg <= xs_reg;
                cy_reg <= cy_reg + BND_W'(1);
            end
            else
            begin
                cx_reg <= cx_reg + BND_W'(1);
            end
        end
    end

    // Corner walker: squares are kept incrementally, (d-1)^2 = d^2 - 2d + 1.
    assign sq_next    = 16'(cmd.radius) * 16'(cmd.radius);
    assign left_base  = CRN_W'(x_reg);
    assign right_base = CRN_W'(x_reg) + CRN_W'(w_reg) - CRN_W'(1);
    assign hit        = (17'(dxsq_reg) + 17'(dysq_reg)) > 17'(rsq_reg);
    assign cand_x     = q_reg[0] ? right_reg : left_reg;
    assign cand_y     = q_reg[1] ? bot_reg : top_reg;
    // Negative coordinates wrap to large values and fail the compare too.
    assign cand_ok    = (cand_x < CRN_FBW) && (cand_y < CRN_FBH);
    assign col_end    = (col_reg == rad_reg - 8'd1);
    assign row_end    = (row_reg == rad_reg - 8'd1);

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            q_reg     <= '0;
            dx_reg    <= cmd.radius;
            dy_reg    <= cmd.radius;
            rsq_reg   <= sq_next;
            dxsq_reg  <= sq_next;
            dysq_reg  <= sq_next;
            left_reg  <= CRN_W'(cmd.pos_x);
            right_reg <= CRN_W'(cmd.pos_x) + CRN_W'(cmd.width) - CRN_W'(1);
            top_reg   <= CRN_W'(cmd.pos_y);
            bot_reg   <= CRN_W'(cmd.pos_y) + CRN_W'(cmd.height) - CRN_W'(1);
        end
        else if (ctl.corner_run)
        begin
            if (hit && q_reg != 2'd3)
            begin
                q_reg <= q_reg + 2'd1;
            end
            else
            begin
                q_reg <= '0;
                if (col_end)
                begin
                    col_reg   <= '0;
                    dx_reg    <= rad_reg;
                    dxsq_reg  <= rsq_reg;
                    left_reg  <= left_base;
                    right_reg <= right_base;
                    row_reg   <= row_reg + 8'd1;
                    dy_reg    <= dy_reg - 8'd1;
                    dysq_reg  <= dysq_reg - {7'd0, dy_reg, 1'b0} + 16'd1;
                    top_reg   <= top_reg + CRN_W'(1);
                    bot_reg   <= bot_reg - CRN_W'(1);
                end
                else
                begin
                    col_reg   <= col_reg + 8'd1;
                    dx_reg    <= dx_reg - 8'd1;
                    dxsq_reg  <= dxsq_reg - {7'd0, dx_reg, 1'b0} + 16'd1;
                    left_reg  <= left_reg + CRN_W'(1);
                    right_reg <= right_reg - CRN_W'(1);
                end
            end
        end
    end

    // Pipeline entry: one pixel write or one read request a cycle.
    always_comb
    begin
        p_we_next   = 1'b0;
        p_x_next    = x_reg;
        p_y_next    = y_reg;
        p_data_next = bg_reg;
        if (ctl.rect_run)
        begin
            p_we_next   = 1'b1;
            p_x_next    = cx_reg[COORD_W-1:0];
            p_y_next    = cy_reg[COORD_W-1:0];
            p_data_next = rcol_reg;
        end
        else if (ctl.corner_run)
        begin
            p_we_next = hit && cand_ok;
            p_x_next  = cand_x[COORD_W-1:0];
            p_y_next  = cand_y[COORD_W-1:0];
        end
        p_ok_next = (x_reg < CRD_FBW) && (y_reg < CRD_FBH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_we_reg  <= 1'b0;
            p_tok_reg <= 1'b0;
            a_we_reg  <= 1'b0;
            a_tok_reg <= 1'b0;
            r_tok_reg <= 1'b0;
        end
        else
        begin
            p_we_reg  <= p_we_next;
            p_tok_reg <= ctl.rd_issue;
            a_we_reg  <= p_we_reg;
            a_tok_reg <= p_tok_reg;
            r_tok_reg <= a_tok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_x_reg    <= p_x_next;
        p_y_reg    <= p_y_next;
        p_data_reg <= p_data_next;
        p_ok_reg   <= p_ok_next;
        a_addr_reg <= ADDR_W'(p_y_reg) * ADDR_W'(FB_WIDTH) + ADDR_W'(p_x_reg);
        a_data_reg <= p_data_reg;
        a_ok_reg   <= p_ok_reg;
        r_ok_reg   <= a_ok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_we_reg)
        begin
            frame_store[a_addr_reg] <= a_data_reg;
        end
        rdata_reg <= frame_store[a_addr_reg];
    end

    // Read value, zero for a point outside the buffer and for other modes.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            rd_pix_reg <= '0;
        end
        else if (r_tok_reg)
        begin
            rd_pix_reg <= r_ok_reg ? rdata_reg : 16'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            rsp_reg.pixel_value <= rd_pix_reg;
            rsp_reg.done_mode   <= mode_reg;
        end
    end

    assign rsp              = rsp_reg;
    assign stat.mode        = mode_reg;
    assign stat.rect_empty  = empty_reg;
    assign stat.rect_last   = wrap && ((cy_reg + BND_W'(1)) == y1_reg);
    assign stat.glyph_none  = (wlim_reg == 5'd0) || (sc_reg == 4'd0);
    assign stat.glyph_last  = (5'(gcol_reg) + 5'd1) == wlim_reg;
    assign stat.corner_none = (rad_reg == 8'd0);
    assign stat.corner_last = row_end && col_end && (!hit || q_reg == 2'd3);
    assign stat.rd_done     = r_tok_reg;
    assign a_addr_ext       = {1'b0, a_addr_reg};

    // Every frame memory write lands inside the buffer.
    `FDE_ASSERT(a_write_in_range, clk, rst_n, a_we_reg |-> (a_addr_ext < ADDR_LIM))
    // The walker never paints a rectangle that clipped away to nothing.
    `FDE_ASSERT_NEVER(a_run_on_empty, clk, rst_n, ctl.rect_run && empty_reg)

endmodule

@@ test/framebuffer_draw_engine_test.sv @@
// Self-checking testbench for the frame buffer draw engine, with its own drawing predictor.
`timescale 1ns / 1ps

module framebuffer_draw_engine_test;

    // Mode codes as the package names them, kept short for the stimulus table.
    localparam logic [2:0] MODE_PIXEL = fde_pkg::MODE_PIXEL;
    localparam logic [2:0] MODE_FILL  = fde_pkg::MODE_FILL;
    localparam logic [2:0] MODE_ROUND = fde_pkg::MODE_ROUND;
    localparam logic [2:0] MODE_GLYPH = fde_pkg::MODE_GLYPH;
    localparam logic [2:0] MODE_CLEAR = fde_pkg::MODE_CLEAR;
    localparam logic [2:0] MODE_READ  = fde_pkg::MODE_READ;

    // The two mode codes that the package leaves unnamed. The engine must draw nothing
    // for them and still answer once, echoing the code.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int FB_W         = fde_pkg::FB_WIDTH_DEF;
    localparam int FB_H         = fde_pkg::FB_HEIGHT_DEF;
    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_PERCENT = 17;
    localparam int MAX_REPORTS  = 10;

    // Rows of the directed table either carry a hand-typed pixel value or rely on
    // the predictor.
    localparam bit TYPED = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct {
        fde_pkg::fde_in_t item;
        bit               typed;
        logic [15:0]      want;
    } plan_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    fde_pkg::fde_in_t  cmd       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    fde_pkg::fde_out_t rsp;

    // Mirror of the frame store, the results still owed by the engine, and the
    // point near which random reads look, so that they mostly land on fresh drawing.
    logic [15:0]       frame_words [0:FB_W*FB_H-1];
    fde_pkg::fde_out_t pending_rsp [$];
    plan_row_t         plan [$];
    int                near_x;
    int                near_y;
    int                fault_count = 0;
    bit                calm = 1'b0;

    framebuffer_draw_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // A run that hangs is stopped here. A normal run needs only a small fraction of
    // this time.
    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void note_fault(string what);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endfunction

    // Writes one word, dropping it when the coordinate lies outside the buffer,
    // negative coordinates from round rectangle corners included.
    function automatic void put_word(int x, int y, logic [15:0] word);
        if (x >= 0 && y >= 0 && x < FB_W && y < FB_H)
            frame_words[y*FB_W + x] = word;
    endfunction

    function automatic void fill_box(int x, int y, int w, int h, logic [15:0] word);
        int x_end;
        int y_end;
        x_end = (x + w > FB_W) ? FB_W : x + w;
        y_end = (y + h > FB_H) ? FB_H : y + h;
        for (int row = y; row < y_end; row++)
            for (int col = x; col < x_end; col++)
                frame_words[row*FB_W + col] = word;
    endfunction

    // Applies one command to the mirror and returns the answer that the engine owes.
    function automatic fde_pkg::fde_out_t draw_and_answer(fde_pkg::fde_in_t c);
        fde_pkg::fde_out_t ans;
        logic [15:0]       fg_word;
        logic [15:0]       bg_word;
        int                x;
        int                y;
        int                w;
        int                h;
        int                rad;
        int                sc;
        int                dx;
        int                dy;
        ans           = '0;
        ans.done_mode = c.mode;
        // Pixels are held with their two bytes exchanged.
        fg_word = {c.fg_color[7:0], c.fg_color[15:8]};
        bg_word = {c.bg_color[7:0], c.bg_color[15:8]};
        x   = int'(c.pos_x);
        y   = int'(c.pos_y);
        w   = int'(c.width);
        h   = int'(c.height);
        rad = int'(c.radius);
        sc  = int'(c.scale);
        case (c.mode)
            MODE_PIXEL:
                put_word(x, y, fg_word);
            MODE_FILL:
                fill_box(x, y, w, h, fg_word);
            MODE_ROUND:
            begin
                fill_box(x, y, w, h, fg_word);
                // Corner points beyond the quarter circle go to the background colour,
                // mirrored into all four corners.
                for (int row = 0; row < rad; row++)
                    for (int col = 0; col < rad; col++)
                    begin
                        dx = rad - col;
                        dy = rad - row;
                        if (dx*dx + dy*dy > rad*rad)
                        begin
                            put_word(x + col, y + row, bg_word);
                            put_word(x + w - 1 - col, y + row, bg_word);
                            put_word(x + col, y + h - 1 - row, bg_word);
                            put_word(x + w - 1 - col, y + h - 1 - row, bg_word);
                        end
                    end
            end
            MODE_GLYPH:
            begin
                if (w > 16)
                    w = 16;
                if (sc != 0)
                    for (int col = 0; col < w; col++)
                        fill_box(x + col*sc, y, sc, sc,
                                 c.glyph_bits[15-col] ? fg_word : bg_word);
            end
            MODE_CLEAR:
                fill_box(0, 0, FB_W, FB_H, fg_word);
            MODE_READ:
                if (x < FB_W && y < FB_H)
                    ans.pixel_value = frame_words[y*FB_W + x];
            default:
                ;
        endcase
        return ans;
    endfunction

    function automatic void add_step(logic [2:0] mode, int x, int y, int w, int h, int rad,
                                     int fg, int bg, int bits, int sc,
                                     bit typed, logic [15:0] want);
        plan_row_t r;
        r.item.mode       = mode;
        r.item.pos_x      = 12'(x);
        r.item.pos_y      = 12'(y);
        r.item.width      = 12'(w);
        r.item.height     = 12'(h);
        r.item.radius     = 8'(rad);
        r.item.fg_color   = 16'(fg);
        r.item.bg_color   = 16'(bg);
        r.item.glyph_bits = 16'(bits);
        r.item.scale      = 4'(sc);
        r.typed           = typed;
        r.want            = want;
        plan.push_back(r);
    endfunction

    // Mostly inside the buffer, some near its far edge and some anywhere in the
    // twelve-bit range.
    function automatic int pick_coord(int span);
        case ($urandom_range(7))
            0: return int'($urandom_range(4095));
            1: return span - 8 + int'($urandom_range(15));
            default: return int'($urandom_range(span - 1));
        endcase
    endfunction

    // Random command. Fields that a mode ignores keep random junk, which the engine
    // must not look at. Sizes are kept mostly small so that the run stays short.
    function automatic fde_pkg::fde_in_t pick_cmd();
        fde_pkg::fde_in_t c;
        int               pick;
        c.pos_x      = 12'($urandom);
        c.pos_y      = 12'($urandom);
        c.width      = 12'($urandom);
        c.height     = 12'($urandom);
        c.radius     = 8'($urandom);
        c.fg_color   = 16'($urandom);
        c.bg_color   = 16'($urandom);
        c.glyph_bits = 16'($urandom);
        c.scale      = 4'($urandom);
        pick = int'($urandom_range(999));
        if (pick < 300)
        begin
            c.mode = MODE_READ;
            if ($urandom_range(9) != 0)
            begin
                c.pos_x = 12'(near_x + int'($urandom_range(15)));
                c.pos_y = 12'(near_y + int'($urandom_range(15)));
            end
        end
        else if (pick < 960)
        begin
            c.pos_x = 12'(pick_coord(FB_W));
            c.pos_y = 12'(pick_coord(FB_H));
            near_x  = int'(c.pos_x);
            near_y  = int'(c.pos_y);
            if (pick < 450)
                c.mode = MODE_PIXEL;
            else if (pick < 650)
            begin
                c.mode = MODE_FILL;
                case ($urandom_range(9))
                    0:
                    begin
                        c.height = 12'($urandom_range(4, 1));
                    end
                    1:
                    begin
                        c.width = 12'($urandom_range(4, 1));
                    end
                    2:
                    begin
                        // Empty rectangle along one axis or the other.
                        c.width  = 12'($urandom_range(8, 1));
                        c.height = 12'($urandom_range(8, 1));
                        if ($urandom_range(1) != 0)
                            c.width = '0;
                        else
                            c.height = '0;
                    end
                    default:
                    begin
                        c.width  = 12'($urandom_range(24, 1));
                        c.height = 12'($urandom_range(24, 1));
                    end
                endcase
            end
            else if (pick < 750)
            begin
                c.mode   = MODE_ROUND;
                c.width  = 12'($urandom_range(40, 1));
                c.height = 12'($urandom_range(40, 1));
                c.radius = ($urandom_range(9) == 0) ? 8'($urandom_range(63))
                                                    : 8'($urandom_range(15));
            end
            else
            begin
                c.mode  = MODE_GLYPH;
                c.width = ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(16, 1));
                c.scale = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3));
            end
        end
        else if (pick < 998)
            c.mode = ($urandom_range(1) != 0) ? MODE_SPARE_7 : MODE_SPARE_6;
        else
            c.mode = MODE_CLEAR;
        return c;
    endfunction

    // Offers one item, with random idle cycles before it, and records the answer it
    // is owed once the engine takes it. Valid is left high afterwards so that a
    // following item can be offered without a gap.
    task automatic send_cmd(fde_pkg::fde_in_t item, bit typed, logic [15:0] want);
        fde_pkg::fde_out_t ans;
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        ans = draw_and_answer(item);
        if (typed)
            ans.pixel_value = want;
        pending_rsp.push_back(ans);
    endtask

    // The result side stalls at random, except during the calm stretch.
    always @(posedge clk)
        rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

    // Every result taken is compared with the oldest answer still owed.
    always @(posedge clk)
    begin : result_check
        fde_pkg::fde_out_t owed;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                note_fault($sformatf("result %h/%0d with no command waiting",
                                     rsp.pixel_value, rsp.done_mode));
            else
            begin
                owed = pending_rsp.pop_front();
                if (rsp.pixel_value !== owed.pixel_value)
                    note_fault($sformatf("pixel_value expected %h, got %h (mode %0d)",
                                         owed.pixel_value, rsp.pixel_value, owed.done_mode));
                if (rsp.done_mode !== owed.done_mode)
                    note_fault($sformatf("done_mode expected %0d, got %0d",
                                         owed.done_mode, rsp.done_mode));
            end
        end
    end

    initial
    begin
        fde_pkg::fde_in_t c;
        int               issued;
        issued = 0;
        near_x = 0;
        near_y = 0;

        // Directed table. The buffer holds nothing defined after reset, so before the
        // clear only pixels just written, or places outside the buffer, are read back.
        //       mode          x     y     w     h     rad  fg       bg       bits     sc
        add_step(MODE_PIXEL,   0,    0,    0,    0,    0,   'h1234,  'h0000,  'h0000,  0,
                 TYPED, 16'h0000);
        add_step(MODE_READ,    0,    0,    0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'h3412);
        add_step(MODE_PIXEL,   319,  239,  4095, 4095, 255, 'hFFFF,  'hFFFF,  'hFFFF,  15,
                 TYPED, 16'h0000);
        add_step(MODE_READ,    319,  239,  0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'hFFFF);
        // A pixel just past the corner is clipped; a read far outside answers zero.
        add_step(MODE_PIXEL,   320,  240,  0,    0,    0,   'h5A5A,  'h0000,  'h0000,  0,
                 TYPED, 16'h0000);
        add_step(MODE_READ,    4095, 4095, 4095, 4095, 255, 'hFFFF,  'hFFFF,  'hFFFF,  15,
                 TYPED, 16'h0000);
        add_step(MODE_CLEAR,   4095, 4095, 4095, 4095, 255, 'h00F8,  'hFFFF,  'hFFFF,  15,
                 TYPED, 16'h0000);
        add_step(MODE_READ,    160,  120,  0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'hF800);
        add_step(MODE_FILL,    10,   10,   20,   10,   0,   'h07E0,  'h0000,  'h0000,  0,
                 TYPED, 16'h0000);
        add_step(MODE_READ,    29,   19,   0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'hE007);
        add_step(MODE_READ,    30,   19,   0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'hF800);
        // A rectangle that runs far beyond the buffer must stop at its edges.
        add_step(MODE_FILL,    300,  230,  4095, 4095, 0,   'h001F,  'h0000,  'h0000,  0,
                 TYPED, 16'h0000);
        add_step(MODE_READ,    319,  239,  0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'h1F00);
        add_step(MODE_ROUND,   40,   40,   30,   20,   6,   'h1111,  'h2222,  'h0000,  0,
                 TYPED, 16'h0000);
        add_step(MODE_READ,    40,   40,   0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'h2222);
        add_step(MODE_READ,    55,   50,   0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'h1111);
        // Largest radius on a tiny rectangle: mirrored corners fall to negative places.
        add_step(MODE_ROUND,   0,    0,    8,    8,    255, 'h00FF,  'hFF00,  'h0000,  0,
                 PREDICTED, 16'h0000);
        add_step(MODE_READ,    3,    3,    0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 PREDICTED, 16'h0000);
        add_step(MODE_ROUND,   100,  60,   200,  100,  128, 'h0F0F,  'hF0F0,  'h0000,  0,
                 PREDICTED, 16'h0000);
        add_step(MODE_READ,    101,  61,   0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 PREDICTED, 16'h0000);
        add_step(MODE_GLYPH,   100,  100,  16,   0,    0,   'h1234,  'h5678,  'h8001,  2,
                 TYPED, 16'h0000);
        add_step(MODE_READ,    102,  101,  0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'h7856);
        add_step(MODE_READ,    131,  101,  0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 TYPED, 16'h3412);
        // Over-wide glyph row saturates at sixteen columns and is clipped at the corner.
        add_step(MODE_GLYPH,   310,  235,  4095, 0,    0,   'hABCD,  'h0000,  'hFFFF,  15,
                 PREDICTED, 16'h0000);
        add_step(MODE_GLYPH,   0,    0,    16,   0,    0,   'hFFFF,  'hFFFF,  'hFFFF,  0,
                 PREDICTED, 16'h0000);
        add_step(MODE_READ,    319,  239,  0,    0,    0,   'h0000,  'h0000,  'h0000,  0,
                 PREDICTED, 16'h0000);
        add_step(MODE_ROUND,   200,  200,  5,    5,    0,   'hCAFE,  'h0000,  'h0000,  0,
                 PREDICTED, 16'h0000);
        add_step(MODE_SPARE_6, 4095, 4095, 4095, 4095, 255, 'hFFFF,  'hFFFF,  'hFFFF,  15,
                 TYPED, 16'h0000);
        add_step(MODE_SPARE_7, 4095, 4095, 4095, 4095, 255, 'hFFFF,  'hFFFF,  'hFFFF,  15,
                 TYPED, 16'h0000);

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_cmd(plan[i].item, plan[i].typed, plan[i].want);

        // Random part. Items of the spare modes are not counted, since the engine
        // ignores them. Both sides run without idling for a stretch in the middle,
        // and every so often the sender waits until the engine has answered everything.
        while (issued < RANDOM_ITEMS)
        begin
            calm = (issued >= 500 && issued < 700);
            c = pick_cmd();
            send_cmd(c, PREDICTED, 16'h0000);
            if (c.mode != MODE_SPARE_6 && c.mode != MODE_SPARE_7)
            begin
                issued++;
                if (issued % 400 == 0)
                begin
                    cmd_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_rsp.size() != 0)
                        @(posedge clk);
                end
            end
        end
        calm = 1'b0;

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        // A little longer, so that a stray extra result would still be caught.
        repeat (100)
            @(posedge clk);

        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/fde_pkg.sv
rtl/core/fde_ctrl.sv
rtl/core/fde_dp.sv
rtl/core/framebuffer_draw_engine.sv
test/framebuffer_draw_engine_test.sv
